### rtl/pidfda_pkg.sv
// shared constants, codes and saturation helpers for the pid controller
// with filtered derivative and anti-windup; no dependencies
package pidfda_pkg;

	localparam int DATA_W = 32;
	localparam int FRAC = 16;
	localparam int LIM_W = DATA_W - 1;
	localparam int PROD_W = 2 * DATA_W;
	localparam int DVD_W = DATA_W + FRAC;
	localparam int CNT_W = $clog2(DVD_W);
	localparam int ADDR_W = 3;

	localparam logic signed [DATA_W-1:0] W_NEW = DATA_W'((64'd1 << FRAC) / 5);
	localparam logic signed [DATA_W-1:0] W_OLD = DATA_W'((64'd1 << FRAC) - ((64'd1 << FRAC) / 5));

	localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	localparam logic [1:0] CLAMP_NONE = 2'd0;
	localparam logic [1:0] CLAMP_UPPER = 2'd1;
	localparam logic [1:0] CLAMP_LOWER = 2'd2;

	localparam logic [ADDR_W-1:0] REG_KP = 3'd0;
	localparam logic [ADDR_W-1:0] REG_KI = 3'd1;
	localparam logic [ADDR_W-1:0] REG_KD = 3'd2;
	localparam logic [ADDR_W-1:0] REG_ILIM = 3'd3;
	localparam logic [ADDR_W-1:0] REG_UPPER = 3'd4;
	localparam logic [ADDR_W-1:0] REG_LOWER = 3'd5;

	// saturate a wide signed value to the data width
	function automatic logic signed [DATA_W-1:0] sat_w(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] hi;
		logic signed [PROD_W-1:0] lo;
		hi = PROD_W'(SAT_MAX);
		lo = PROD_W'(SAT_MIN);
		if (v > hi) begin
			return SAT_MAX;
		end else if (v < lo) begin
			return SAT_MIN;
		end
		return v[DATA_W-1:0];
	endfunction

	// product back to fixed point, rounding toward minus infinity
	function automatic logic signed [DATA_W-1:0] sat_q(input logic signed [PROD_W-1:0] p);
		return sat_w(p >>> FRAC);
	endfunction

endpackage

### rtl/pidfda_if.sv
// valid/ready channel interfaces for sample, result and register write
// depends on pidfda_pkg
interface pidfda_in_if;
	logic valid;
	logic ready;
	logic operation;
	logic signed [pidfda_pkg::DATA_W-1:0] error_sample;
	logic signed [pidfda_pkg::DATA_W-1:0] time_step;
	modport source (output valid, output operation, output error_sample, output time_step,
		input ready);
	modport sink (input valid, input operation, input error_sample, input time_step,
		output ready);
endinterface

interface pidfda_out_if;
	logic valid;
	logic ready;
	logic signed [pidfda_pkg::DATA_W-1:0] drive_value;
	logic [1:0] clamp_status;
	modport source (output valid, output drive_value, output clamp_status, input ready);
	modport sink (input valid, input drive_value, input clamp_status, output ready);
endinterface

interface pidfda_cfg_if;
	logic valid;
	logic ready;
	logic [pidfda_pkg::ADDR_W-1:0] addr;
	logic [pidfda_pkg::DATA_W-1:0] data;
	modport source (output valid, output addr, output data, input ready);
	modport sink (input valid, input addr, input data, output ready);
endinterface

### rtl/pid_filtered_derivative_antiwindup.sv
// pid controller top level: sequencer, shared multiplier, serial divider
// depends on pidfda_pkg and the channel interfaces in pidfda_if.sv
//
// sample channel carries operation, error_sample and time_step (Q16.16).
// result channel returns drive_value and clamp_status, one per sample.
// cfg channel writes gains, integral limit and drive clamps; always ready,
// writes are expected only while no sample is in flight.
// one shared 32x32 multiplier (registered product) is reused for the
// proportional, integral step, integral, derivative and filter products;
// the derivative divide by time_step is a restoring divider, one quotient
// bit per cycle over 48 bits.
// an update runs the multiplier steps, the divider and the filter step before
// the final step; a clear or a time_step of zero or less goes straight there.
// sample.ready is high only while the sequencer is idle, so a new sample is
// accepted only once the previous one has left the final step.
// the result sits in an output register; the next sample is accepted while
// it waits, and a new result is held in the final step until the receiver
// takes the old one.
// reset clears the controller state and loads the register reset values.
module pid_filtered_derivative_antiwindup (
	input logic clk,
	input logic arst_n,
	pidfda_in_if.sink sample,
	pidfda_out_if.source result,
	pidfda_cfg_if.sink cfg
);

	typedef enum logic [11:0] {
		S_IDLE = 12'b0000_0000_0001,
		S_MUL_P = 12'b0000_0000_0010,
		S_MUL_S = 12'b0000_0000_0100,
		S_INTEG = 12'b0000_0000_1000,
		S_MUL_I = 12'b0000_0001_0000,
		S_MUL_D = 12'b0000_0010_0000,
		S_DIV_INIT = 12'b0000_0100_0000,
		S_DIV = 12'b0000_1000_0000,
		S_DIV_END = 12'b0001_0000_0000,
		S_MUL_F2 = 12'b0010_0000_0000,
		S_FILT = 12'b0100_0000_0000,
		S_DONE = 12'b1000_0000_0000
	} state_t;

	localparam int DW = pidfda_pkg::DATA_W;
	localparam int PW = pidfda_pkg::PROD_W;
	localparam int VW = pidfda_pkg::DVD_W;
	localparam int CW = pidfda_pkg::CNT_W;
	localparam int LW = pidfda_pkg::LIM_W;

	state_t state_q;

	logic signed [DW-1:0] kp_q, ki_q, kd_q, upper_q, lower_q;
	logic [LW-1:0] ilim_q;

	logic signed [DW-1:0] isum_q, last_q, filt_q;

	logic signed [DW-1:0] err_q, dt_q, p_q, i_q, step_q, diff_q, draw_q, pi_q;
	logic zero_q;
	logic signed [PW-1:0] prod_q, acc_q;

	logic [VW-1:0] dvd_q;
	logic [LW-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic neg_q;

	logic out_vld_q;
	logic signed [DW-1:0] out_drive_q;
	logic [1:0] out_clamp_q;

	logic signed [DW-1:0] mul_a, mul_b;
	logic signed [DW-1:0] step_c, num_c, isum_add, filt_c, drive_c;
	logic signed [DW:0] ilim_pos, ilim_neg, isum_x;
	logic [DW:0] num_mag;
	logic [LW:0] rsh;
	logic [LW:0] rsub;
	logic qbit;
	logic signed [PW-1:0] quot_s;
	logic out_free;
	logic out_load;
	logic clamp_en;

	assign sample.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign result.valid = out_vld_q;
	assign result.drive_value = out_drive_q;
	assign result.clamp_status = out_clamp_q;

	assign out_free = !out_vld_q || result.ready;
	assign out_load = (state_q == S_DONE) && out_free;

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_MUL_P: begin
				mul_a = kp_q;
				mul_b = err_q;
			end
			S_MUL_S: begin
				mul_a = err_q;
				mul_b = dt_q;
			end
			S_MUL_I: begin
				mul_a = ki_q;
				mul_b = isum_q;
			end
			S_MUL_D: begin
				mul_a = kd_q;
				mul_b = diff_q;
			end
			S_DIV_END: begin
				mul_a = pidfda_pkg::W_OLD;
				mul_b = filt_q;
			end
			S_MUL_F2: begin
				mul_a = pidfda_pkg::W_NEW;
				mul_b = draw_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// integral update with symmetric clamp, derivative numerator, filter sum, drive and clamp enable
	always_comb begin
		step_c = pidfda_pkg::sat_q(prod_q);
		isum_add = pidfda_pkg::sat_w(PW'(isum_q) + PW'(step_c));
		ilim_pos = (DW+1)'(ilim_q);
		ilim_neg = -ilim_pos;
		isum_x = (DW+1)'(isum_add);
		num_c = pidfda_pkg::sat_q(prod_q);
		num_mag = num_c[DW-1] ? -((DW+1)'(num_c)) : (DW+1)'(num_c);
		filt_c = pidfda_pkg::sat_w((acc_q + prod_q) >>> pidfda_pkg::FRAC);
		drive_c = pidfda_pkg::sat_w(PW'(pi_q) + PW'(filt_q));
		clamp_en = (upper_q > 0) || (lower_q < 0);
	end

	// restoring divide step and signed quotient
	always_comb begin
		rsh = {rem_q, dvd_q[VW-1]};
		rsub = rsh - {1'b0, dt_q[LW-1:0]};
		qbit = (rsh >= {1'b0, dt_q[LW-1:0]});
		quot_s = neg_q ? -(PW'(dvd_q)) : PW'(dvd_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q <= '0;
			ki_q <= '0;
			kd_q <= '0;
			ilim_q <= '1;
			upper_q <= '0;
			lower_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.addr)
				pidfda_pkg::REG_KP: kp_q <= cfg.data;
				pidfda_pkg::REG_KI: ki_q <= cfg.data;
				pidfda_pkg::REG_KD: kd_q <= cfg.data;
				pidfda_pkg::REG_ILIM: ilim_q <= cfg.data[LW-1:0];
				pidfda_pkg::REG_UPPER: upper_q <= cfg.data;
				pidfda_pkg::REG_LOWER: lower_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			isum_q <= '0;
			last_q <= '0;
			filt_q <= '0;
			out_vld_q <= 1'b0;
			out_drive_q <= '0;
			out_clamp_q <= pidfda_pkg::CLAMP_NONE;
			zero_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && result.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (sample.valid) begin
						err_q <= sample.error_sample;
						dt_q <= sample.time_step;
						if (sample.operation == pidfda_pkg::OP_CLEAR) begin
							isum_q <= '0;
							last_q <= '0;
							filt_q <= '0;
							zero_q <= 1'b1;
							state_q <= S_DONE;
						end else if (sample.time_step <= 0) begin
							zero_q <= 1'b1;
							state_q <= S_DONE;
						end else begin
							zero_q <= 1'b0;
							state_q <= S_MUL_P;
						end
					end
				end
				S_MUL_P: state_q <= S_MUL_S;
				S_MUL_S: begin
					p_q <= pidfda_pkg::sat_q(prod_q);
					state_q <= S_INTEG;
				end
				S_INTEG: begin
					step_q <= step_c;
					if (isum_x > ilim_pos) begin
						isum_q <= ilim_pos[DW-1:0];
					end else if (isum_x < ilim_neg) begin
						isum_q <= ilim_neg[DW-1:0];
					end else begin
						isum_q <= isum_add;
					end
					diff_q <= pidfda_pkg::sat_w(PW'(err_q) - PW'(last_q));
					state_q <= S_MUL_I;
				end
				S_MUL_I: state_q <= S_MUL_D;
				S_MUL_D: begin
					i_q <= pidfda_pkg::sat_q(prod_q);
					state_q <= S_DIV_INIT;
				end
				S_DIV_INIT: begin
					dvd_q <= {num_mag[DW-1:0], {pidfda_pkg::FRAC{1'b0}}};
					neg_q <= num_c[DW-1];
					rem_q <= '0;
					cnt_q <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					rem_q <= qbit ? rsub[LW-1:0] : rsh[LW-1:0];
					dvd_q <= {dvd_q[VW-2:0], qbit};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(VW - 1)) begin
						state_q <= S_DIV_END;
					end
				end
				S_DIV_END: begin
					draw_q <= pidfda_pkg::sat_w(quot_s);
					state_q <= S_MUL_F2;
				end
				S_MUL_F2: begin
					acc_q <= prod_q;
					state_q <= S_FILT;
				end
				S_FILT: begin
					filt_q <= filt_c;
					last_q <= err_q;
					pi_q <= pidfda_pkg::sat_w(PW'(p_q) + PW'(i_q));
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
						if (zero_q) begin
							out_drive_q <= '0;
							out_clamp_q <= pidfda_pkg::CLAMP_NONE;
						end else if (clamp_en && (drive_c > upper_q)) begin
							out_drive_q <= upper_q;
							out_clamp_q <= pidfda_pkg::CLAMP_UPPER;
							if (err_q > 0) begin
								isum_q <= pidfda_pkg::sat_w(PW'(isum_q) - PW'(step_q));
							end
						end else if (clamp_en && (drive_c < lower_q)) begin
							out_drive_q <= lower_q;
							out_clamp_q <= pidfda_pkg::CLAMP_LOWER;
							if (err_q < 0) begin
								isum_q <= pidfda_pkg::sat_w(PW'(isum_q) - PW'(step_q));
							end
						end else begin
							out_drive_q <= drive_c;
							out_clamp_q <= pidfda_pkg::CLAMP_NONE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// integral stays within the limit once clamped
	a_isum_limited: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL_I) |-> (isum_x <= ilim_pos || 1'b1) &&
		((DW+1)'(isum_q) <= ilim_pos) && ((DW+1)'(isum_q) >= ilim_neg))
		else $error("integral outside limit after clamp");

	// divider runs exactly its bit count
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV_END) |-> ($past(state_q) == S_DIV) && (cnt_q == CW'(VW)))
		else $error("divider step count wrong");

	// accepted sample leaves idle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready) |=> (state_q != S_IDLE))
		else $error("sequencer stayed idle after transaction");

	// an upper clamped result carries the upper clamp value
	a_clamp_upper: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_clamp_q == pidfda_pkg::CLAMP_UPPER) |-> (out_drive_q == upper_q))
		else $error("upper clamp status without upper drive");

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !result.ready) |=> out_vld_q && $stable(out_drive_q))
		else $error("result overwritten while waiting");

endmodule

### tb/tb_pid_filtered_derivative_antiwindup.sv
// self-checking testbench for the pid controller with filtered derivative and anti-windup
// drives samples in bursts, stalls results, checks every result against a built-in predictor
// depends on pidfda_pkg, the channel interfaces and the top level in rtl
module tb_pid_filtered_derivative_antiwindup;
	timeunit 1ns;
	timeprecision 1ps;

	import pidfda_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 700000;
	localparam int ITEMS_PER_SETTING = 50;
	localparam logic [ADDR_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [ADDR_W-1:0] REG_SPARE_B = 3'd7;

	typedef struct {
		logic operation;
		logic signed [DATA_W-1:0] error_sample;
		logic signed [DATA_W-1:0] time_step;
	} sample_t;

	typedef struct {
		logic signed [DATA_W-1:0] drive_value;
		logic [1:0] clamp_status;
	} drive_t;

	logic clk;
	logic arst_n;

	pidfda_in_if sample_ch ();
	pidfda_out_if result_ch ();
	pidfda_cfg_if cfg_ch ();

	pid_filtered_derivative_antiwindup i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample_ch),
		.result(result_ch),
		.cfg(cfg_ch)
	);

	// controller copy
	longint gain_p = 0;
	longint gain_i = 0;
	longint gain_d = 0;
	longint int_limit = 64'h7FFF_FFFF;
	longint drv_hi = 0;
	longint drv_lo = 0;
	longint integ_acc = 0;
	longint prev_error = 0;
	longint deriv_lp = 0;

	sample_t sample_q[$];
	drive_t expected_drive_q[$];

	int fail_count = 0;
	int n_update = 0;
	int n_clear = 0;
	int n_skip = 0;
	int n_upper = 0;
	int n_lower = 0;
	int n_results = 0;
	int n_settings = 0;
	int unsigned cycle_count = 0;
	longint track_err = 0;

	sample_t drv_item;
	sample_t seen_item;
	drive_t want;
	int unsigned burst_left;
	int unsigned gap_left;
	int unsigned rx_mode;
	int unsigned rx_mode_left;
	int unsigned rx_hold;

	task automatic note_failure(input string msg);
		$display("ERROR %s", msg);
		fail_count++;
	endtask

	function automatic longint clip32(input longint v);
		if (v > longint'(SAT_MAX)) return longint'(SAT_MAX);
		if (v < longint'(SAT_MIN)) return longint'(SAT_MIN);
		return v;
	endfunction

	function automatic longint qmul(input longint a, input longint b);
		return clip32((a * b) >>> FRAC);
	endfunction

	function automatic drive_t predict_step(input sample_t s);
		drive_t r;
		longint err;
		longint dt;
		longint p_term;
		longint i_term;
		longint inc;
		longint diff;
		longint num;
		longint d_raw;
		longint drive;
		r.drive_value = '0;
		r.clamp_status = CLAMP_NONE;
		err = s.error_sample;
		dt = s.time_step;
		if (s.operation == OP_CLEAR) begin
			integ_acc = 0;
			prev_error = 0;
			deriv_lp = 0;
			n_clear++;
			return r;
		end
		if (dt <= 0) begin
			n_skip++;
			return r;
		end
		n_update++;
		p_term = qmul(gain_p, err);
		inc = qmul(err, dt);
		integ_acc = clip32(integ_acc + inc);
		if (integ_acc > int_limit) begin
			integ_acc = int_limit;
		end else if (integ_acc < -int_limit) begin
			integ_acc = -int_limit;
		end
		i_term = qmul(gain_i, integ_acc);
		diff = clip32(err - prev_error);
		num = qmul(gain_d, diff);
		d_raw = clip32((num * (longint'(1) <<< FRAC)) / dt);
		deriv_lp = clip32((longint'(W_OLD) * deriv_lp + longint'(W_NEW) * d_raw) >>> FRAC);
		prev_error = err;
		drive = clip32(clip32(p_term + i_term) + deriv_lp);
		if (drv_hi > 0 || drv_lo < 0) begin
			if (drive > drv_hi) begin
				drive = drv_hi;
				r.clamp_status = CLAMP_UPPER;
				n_upper++;
				if (err > 0) integ_acc = clip32(integ_acc - inc);
			end else if (drive < drv_lo) begin
				drive = drv_lo;
				r.clamp_status = CLAMP_LOWER;
				n_lower++;
				if (err < 0) integ_acc = clip32(integ_acc - inc);
			end
		end
		r.drive_value = drive[DATA_W-1:0];
		return r;
	endfunction

	function automatic void apply_register(input logic [ADDR_W-1:0] index,
		input logic [DATA_W-1:0] value);
		case (index)
			REG_KP: gain_p = longint'($signed(value));
			REG_KI: gain_i = longint'($signed(value));
			REG_KD: gain_d = longint'($signed(value));
			REG_ILIM: int_limit = longint'(value[LIM_W-1:0]);
			REG_UPPER: drv_hi = longint'($signed(value));
			REG_LOWER: drv_lo = longint'($signed(value));
			default: ;
		endcase
	endfunction

	function automatic logic signed [DATA_W-1:0] rand_span(input int unsigned span);
		longint v;
		v = longint'($urandom_range(0, 2 * span)) - longint'(span);
		return v[DATA_W-1:0];
	endfunction

	function automatic sample_t mk(input logic op, input logic signed [DATA_W-1:0] err,
		input logic signed [DATA_W-1:0] dt);
		sample_t s;
		s.operation = op;
		s.error_sample = err;
		s.time_step = dt;
		return s;
	endfunction

	function automatic sample_t make_sample();
		sample_t s;
		int unsigned pick;
		longint e;
		pick = $urandom_range(0, 99);
		s.operation = OP_UPDATE;
		s.error_sample = $urandom;
		s.time_step = $urandom;
		if (pick < 4) begin
			s.operation = OP_CLEAR;
		end else if (pick < 7) begin
			s.time_step = '0;
		end else if (pick < 10) begin
			s.time_step = $urandom | 32'h8000_0000;
		end else if (pick >= 18) begin
			case ($urandom_range(0, 3))
				0: s.error_sample = rand_span(32'h0004_0000);
				1: begin
					e = track_err + longint'(rand_span(32'h0000_8000));
					if (e > 64'sh0100_0000) e = 64'sh0100_0000;
					if (e < -64'sh0100_0000) e = -64'sh0100_0000;
					track_err = e;
					s.error_sample = e[DATA_W-1:0];
				end
				2: s.error_sample = rand_span(32'h0100_0000);
				default: s.error_sample = rand_span(32'h4000_0000);
			endcase
			case ($urandom_range(0, 3))
				0: s.time_step = $urandom_range(1, 16);
				3: s.time_step = $urandom_range(1, 32'h7FFF_FFFF);
				default: s.time_step = $urandom_range(32'h0000_0100, 32'h0002_0000);
			endcase
		end
		return s;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned k;
		k = $urandom_range(0, 9);
		if (k < 5) return $urandom_range(0, 3);
		if (k < 9) return $urandom_range(4, 70);
		return $urandom_range(71, 150);
	endfunction

	task automatic write_reg(input logic [ADDR_W-1:0] index, input logic [DATA_W-1:0] value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.addr <= index;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic program_setting(input int kind);
		logic [DATA_W-1:0] kp;
		logic [DATA_W-1:0] ki;
		logic [DATA_W-1:0] kd;
		logic [DATA_W-1:0] ilim;
		logic [DATA_W-1:0] up;
		logic [DATA_W-1:0] lo;
		kp = rand_span(32'h0008_0000);
		ki = rand_span(32'h0008_0000);
		kd = rand_span(32'h0008_0000);
		ilim = {1'($urandom_range(0, 1)), 31'($urandom_range(0, 32'h0064_0000))};
		up = $urandom_range(1, 32'h0020_0000);
		lo = -$urandom_range(1, 32'h0020_0000);
		case (kind)
			0: begin
				kp = 32'h0001_0000;
				ki = 32'h0000_8000;
				kd = 32'h0000_4000;
				ilim = 32'h0032_0000;
				up = 32'h000A_0000;
				lo = -32'h000A_0000;
			end
			1: begin
				kp = SAT_MAX;
				ki = SAT_MAX;
				kd = SAT_MAX;
				ilim = 32'hFFFF_FFFF;
				up = SAT_MAX;
				lo = SAT_MIN;
			end
			2: begin
				kp = SAT_MIN;
				ki = SAT_MIN;
				kd = SAT_MIN;
				ilim = '0;
				up = '0;
				lo = '0;
			end
			4: begin
				up = $urandom_range(1, 32'h0004_0000);
				lo = up + $urandom_range(1, 32'h0004_0000);
			end
			5: begin
				up = -$urandom_range(1, 32'h0004_0000);
				lo = up - $urandom_range(0, 32'h0004_0000);
			end
			6: begin
				kp = $urandom;
				ki = $urandom;
				kd = $urandom;
				ilim = $urandom;
				up = $urandom;
				lo = $urandom;
				write_reg(REG_SPARE_A, $urandom);
				write_reg(REG_SPARE_B, $urandom);
			end
			7: begin
				kp = rand_span(32'h0040_0000);
				ki = rand_span(32'h0040_0000);
				kd = rand_span(32'h0040_0000);
				ilim = $urandom_range(0, 32'h0000_8000);
				up = '0;
			end
			default: ;
		endcase
		write_reg(REG_KP, kp);
		write_reg(REG_KI, ki);
		write_reg(REG_KD, kd);
		write_reg(REG_ILIM, ilim);
		write_reg(REG_UPPER, up);
		write_reg(REG_LOWER, lo);
		n_settings++;
	endtask

	task automatic wait_idle();
		while (sample_q.size() != 0 || sample_ch.valid || expected_drive_q.size() != 0)
			@(negedge clk);
		repeat (64) @(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAIL pid_filtered_derivative_antiwindup");
			$finish;
		end
	end

	// sample driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_ch.valid <= 1'b0;
			sample_ch.operation <= OP_UPDATE;
			sample_ch.error_sample <= '0;
			sample_ch.time_step <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!sample_ch.valid || sample_ch.ready) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				sample_ch.valid <= 1'b0;
			end else if (sample_q.size() != 0) begin
				drv_item = sample_q.pop_front();
				sample_ch.valid <= 1'b1;
				sample_ch.operation <= drv_item.operation;
				sample_ch.error_sample <= drv_item.error_sample;
				sample_ch.time_step <= drv_item.time_step;
				if (burst_left <= 1) begin
					burst_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) :
						$urandom_range(1, 8);
					gap_left <= pick_gap();
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				sample_ch.valid <= 1'b0;
			end
		end
	end

	// result stall pattern: free running, random, long holds
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			rx_mode <= 0;
			rx_mode_left <= 0;
			rx_hold <= 0;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode <= $urandom_range(0, 2);
				rx_mode_left <= $urandom_range(20, 300);
			end else begin
				rx_mode_left <= rx_mode_left - 1;
			end
			case (rx_mode)
				0: result_ch.ready <= 1'b1;
				1: result_ch.ready <= 1'($urandom_range(0, 1));
				default: begin
					if (rx_hold == 0) begin
						result_ch.ready <= !result_ch.ready;
						rx_hold <= result_ch.ready ? $urandom_range(1, 40) :
							$urandom_range(1, 5);
					end else begin
						rx_hold <= rx_hold - 1;
					end
				end
			endcase
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) apply_register(cfg_ch.addr, cfg_ch.data);
			if (result_ch.valid && result_ch.ready) begin
				if (expected_drive_q.size() == 0) begin
					note_failure($sformatf("unexpected result transaction: drive %0d status %0d",
						result_ch.drive_value, result_ch.clamp_status));
				end else begin
					want = expected_drive_q.pop_front();
					n_results++;
					if (result_ch.drive_value !== want.drive_value)
						note_failure($sformatf("result %0d drive_value got %0d expected %0d",
							n_results, result_ch.drive_value, want.drive_value));
					if (result_ch.clamp_status !== want.clamp_status)
						note_failure($sformatf("result %0d clamp_status got %0d expected %0d",
							n_results, result_ch.clamp_status, want.clamp_status));
				end
			end
			if (sample_ch.valid && sample_ch.ready) begin
				seen_item.operation = sample_ch.operation;
				seen_item.error_sample = sample_ch.error_sample;
				seen_item.time_step = sample_ch.time_step;
				expected_drive_q.push_back(predict_step(seen_item));
			end
		end
	end

	initial begin
		int kinds[10];
		kinds = '{1, 2, 3, 4, 5, 6, 7, 3, 6, 4};
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.addr = REG_KP;
		cfg_ch.data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (4) @(negedge clk);

		program_setting(0);
		@(negedge clk);
		sample_q.push_back(mk(OP_UPDATE, 32'sh0001_0000, 32'sd655));
		sample_q.push_back(mk(OP_UPDATE, 32'sh0002_0000, 32'sh0001_0000));
		sample_q.push_back(mk(OP_UPDATE, 32'sh0005_0000, 32'sd0));
		sample_q.push_back(mk(OP_UPDATE, 32'sh0005_0000, -32'sh0001_0000));
		sample_q.push_back(mk(OP_UPDATE, 32'sh0005_0000, SAT_MIN));
		sample_q.push_back(mk(OP_UPDATE, SAT_MAX, SAT_MAX));
		sample_q.push_back(mk(OP_UPDATE, SAT_MIN, SAT_MAX));
		sample_q.push_back(mk(OP_UPDATE, SAT_MAX, 32'sd1));
		sample_q.push_back(mk(OP_UPDATE, SAT_MIN, 32'sd1));
		sample_q.push_back(mk(OP_CLEAR, SAT_MAX, SAT_MIN));
		sample_q.push_back(mk(OP_UPDATE, 32'sd0, 32'sd1));
		sample_q.push_back(mk(OP_UPDATE, 32'sh0064_0000, 32'sh0002_0000));
		sample_q.push_back(mk(OP_UPDATE, 32'sh0064_0000, 32'sh0002_0000));
		sample_q.push_back(mk(OP_UPDATE, -32'sh0064_0000, 32'sh0002_0000));
		sample_q.push_back(mk(OP_UPDATE, -32'sh0064_0000, 32'sh0002_0000));
		sample_q.push_back(mk(OP_CLEAR, 32'sd0, 32'sd0));
		// upper clamp with a positive error, then lower clamp with a negative error; both back out the integral step
		sample_q.push_back(mk(OP_UPDATE, 32'sh0028_0000, 32'sh0002_0000));
		sample_q.push_back(mk(OP_UPDATE, -32'sh0000_8000, 32'sd655));
		sample_q.push_back(mk(OP_CLEAR, 32'sd1, 32'sd1));
		sample_q.push_back(mk(OP_UPDATE, -32'sh0028_0000, 32'sh0002_0000));
		sample_q.push_back(mk(OP_UPDATE, 32'sh0000_8000, 32'sd655));
		sample_q.push_back(mk(OP_UPDATE, -32'sh0003_0000, 32'sh0000_8000));
		sample_q.push_back(mk(OP_UPDATE, 32'sh001E_0000, 32'sd6554));
		sample_q.push_back(mk(OP_UPDATE, 32'sd1, 32'sh7FFF_FFFF));

		foreach (kinds[k]) begin
			wait_idle();
			program_setting(kinds[k]);
			@(negedge clk);
			repeat (ITEMS_PER_SETTING) sample_q.push_back(make_sample());
		end

		wait_idle();
		repeat (16) @(negedge clk);
		$display("covered %0d updates, %0d clears and %0d skipped steps over %0d register settings",
			n_update, n_clear, n_skip, n_settings);
		$display("clamped high %0d and low %0d times; %0d results checked, %0d mismatches",
			n_upper, n_lower, n_results, fail_count);
		if (fail_count == 0 && expected_drive_q.size() == 0) begin
			$display("PASS pid_filtered_derivative_antiwindup");
		end else begin
			$display("FAIL pid_filtered_derivative_antiwindup");
		end
		$finish;
	end

endmodule

### files.f
rtl/pidfda_pkg.sv
rtl/pidfda_if.sv
rtl/pid_filtered_derivative_antiwindup.sv
tb/tb_pid_filtered_derivative_antiwindup.sv
